// ----- hdl/mrrt_pkg.sv -----
// Shared types, codes and controller/datapath interface structs for the request table.
package mrrt_pkg;

  // Action codes of an incoming request
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_FIND = 1'b1;

  // Result status codes
  localparam logic [1:0] STS_ADDED    = 2'd0;
  localparam logic [1:0] STS_EVICTED  = 2'd1;
  localparam logic [1:0] STS_FOUND    = 2'd2;
  localparam logic [1:0] STS_NOTFOUND = 2'd3;

  // Incoming request payload
  typedef struct packed {
    logic        action;
    logic [30:0] request_id;
    logic [30:0] account;
    logic [2:0]  command;
    logic [63:0] symbol_code;
    logic [23:0] lot_count;
    logic [63:0] price_bits;
    logic [31:0] timestamp;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] found_id;
    logic [30:0] found_account;
    logic [2:0]  found_command;
    logic [63:0] found_symbol;
    logic [23:0] found_lots;
    logic [63:0] found_price;
    logic [31:0] found_time;
  } res_t;

  // One stored table entry
  typedef struct packed {
    logic [30:0] id;
    logic [30:0] account;
    logic [2:0]  command;
    logic [63:0] symbol;
    logic [23:0] lots;
    logic [63:0] price;
    logic [31:0] stamp;
  } entry_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic add;
    logic scan;
    logic shift;
    logic deliver;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic req_add;
    logic scan_hit;
    logic scan_miss;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/mrrt_ctrl.sv -----
// Controller state machine: sequences add, scan, compaction and result delivery.
module mrrt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mrrt_pkg::sts_t sts,
  output mrrt_pkg::cmd_t cmd
);
  import mrrt_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = sts.req_add ? ST_ADD : ST_SCAN;
        end
      end
      ST_ADD: begin
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (sts.scan_hit) begin
          state_next = ST_SHIFT;
        end else if (sts.scan_miss) begin
          state_next = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (sts.shift_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      ST_ADD:   cmd.add     = 1'b1;
      ST_SCAN:  cmd.scan    = 1'b1;
      ST_SHIFT: cmd.shift   = 1'b1;
      ST_DONE:  cmd.deliver = sts.out_free;
      default: begin
        cmd       = '0;
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/mrrt_datapath.sv -----
// Datapath: ring-buffer entry memory, scan compare, compaction pointers, result register.
module mrrt_datapath #(
  parameter int TABLE_DEPTH = 128,
  parameter int DROP_COUNT  = 30
) (
  input  logic           clk,
  input  logic           rst,
  input  mrrt_pkg::cmd_t  cmd,
  output mrrt_pkg::sts_t  sts,
  input  mrrt_pkg::req_t  req_data,
  output logic           res_valid,
  input  logic           res_ready,
  output mrrt_pkg::res_t  res_data
);
  import mrrt_pkg::*;

  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int CW       = $clog2(TABLE_DEPTH + 1);
  localparam int DROP_EFF = (DROP_COUNT >= TABLE_DEPTH) ? TABLE_DEPTH : DROP_COUNT;
  localparam logic [AW-1:0] LAST_PTR      = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT      = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] CNT_AFTER_DROP = CW'(TABLE_DEPTH - DROP_EFF + 1);
  localparam logic [AW:0]   DEPTH_W       = (AW + 1)'(TABLE_DEPTH);
  localparam logic [AW:0]   DROP_W        = (AW + 1)'(DROP_EFF);

  // Entry storage, oldest entry at head, next free slot at tail
  entry_t mem [TABLE_DEPTH];

  // Table bookkeeping
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;

  // Scan and compaction state
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] rd_cnt;
  logic          rd_vld;
  logic [AW-1:0] rd_addr_q;
  entry_t        rdata;
  logic [AW-1:0] sh_src;
  logic [AW-1:0] sh_dst;

  // Captured request, matched entry and result
  req_t          req_q;
  entry_t        hit;
  logic [1:0]    res_status;

  logic          full;
  logic          match;
  logic          hit_now;
  logic          scan_issue;
  logic          scan_miss;
  logic          sh_issue;
  logic          sh_done;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        new_entry;
  logic [AW:0]   hd_sum;
  logic [AW-1:0] head_dropped;

  // Wrapping pointer increment
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + AW'(1);
  endfunction

  // Entry built from the captured request
  always_comb begin
    new_entry.id      = req_q.request_id;
    new_entry.account = req_q.account;
    new_entry.command = req_q.command;
    new_entry.symbol  = req_q.symbol_code;
    new_entry.lots    = req_q.lot_count;
    new_entry.price   = req_q.price_bits;
    new_entry.stamp   = req_q.timestamp;
  end

  // Head after discarding the oldest entries of a full table
  assign hd_sum       = {1'b0, head} + DROP_W;
  assign head_dropped = (hd_sum >= DEPTH_W) ? AW'(hd_sum - DEPTH_W) : hd_sum[AW-1:0];
  assign full         = (count == FULL_CNT);

  // Key compare on the registered read data (price is not part of the key)
  assign match = (rdata.account == req_q.account) && (rdata.command == req_q.command) &&
                 (rdata.symbol == req_q.symbol_code) && (rdata.lots == req_q.lot_count);
  assign hit_now    = cmd.scan && rd_vld && match;
  assign scan_issue = cmd.scan && !hit_now && (rd_cnt != count);
  assign scan_miss  = cmd.scan && !rd_vld && (rd_cnt == count);

  // Compaction: read one slot ahead, write the data one slot back
  assign sh_issue = cmd.shift && (sh_src != tail);
  assign sh_done  = cmd.shift && !rd_vld && (sh_src == tail);

  // Memory port selection
  assign rd_en   = scan_issue || sh_issue;
  assign rd_addr = cmd.shift ? sh_src : rd_ptr;
  assign mem_we  = cmd.add || (cmd.shift && rd_vld);
  assign wr_addr = cmd.shift ? sh_dst : tail;
  assign wr_data = cmd.shift ? rdata : new_entry;

  // Status to controller
  always_comb begin
    sts.req_add    = (req_data.action == ACT_ADD);
    sts.scan_hit   = hit_now;
    sts.scan_miss  = scan_miss;
    sts.shift_done = sh_done;
    sts.out_free   = !res_valid || res_ready;
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rd_ptr    <= '0;
      rd_cnt    <= '0;
      rd_vld    <= 1'b0;
      sh_src    <= '0;
      sh_dst    <= '0;
      res_valid <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (cmd.accept) begin
        rd_ptr <= head;
        rd_cnt <= '0;
      end
      if (scan_issue) begin
        rd_ptr <= ptr_inc(rd_ptr);
        rd_cnt <= rd_cnt + CW'(1);
      end
      if (hit_now) begin
        sh_dst <= rd_addr_q;
        sh_src <= ptr_inc(rd_addr_q);
      end
      if (sh_issue) begin
        sh_src <= ptr_inc(sh_src);
      end
      if (cmd.shift && rd_vld) begin
        sh_dst <= ptr_inc(sh_dst);
      end
      if (sh_done) begin
        tail  <= sh_dst;
        count <= count - CW'(1);
      end
      if (cmd.add) begin
        tail <= ptr_inc(tail);
        if (full) begin
          head  <= head_dropped;
          count <= CNT_AFTER_DROP;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.deliver) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req_data;
    end
    if (hit_now) begin
      hit <= rdata;
    end
    if (cmd.add) begin
      res_status <= full ? STS_EVICTED : STS_ADDED;
    end else if (scan_miss) begin
      res_status <= STS_NOTFOUND;
    end else if (sh_done) begin
      res_status <= STS_FOUND;
    end
    if (cmd.deliver) begin
      res_data.status <= res_status;
      if (res_status == STS_FOUND) begin
        res_data.found_id      <= hit.id;
        res_data.found_account <= hit.account;
        res_data.found_command <= hit.command;
        res_data.found_symbol  <= hit.symbol;
        res_data.found_lots    <= hit.lots;
        res_data.found_price   <= hit.price;
        res_data.found_time    <= hit.stamp;
      end else begin
        res_data.found_id      <= '0;
        res_data.found_account <= '0;
        res_data.found_command <= '0;
        res_data.found_symbol  <= '0;
        res_data.found_lots    <= '0;
        res_data.found_price   <= '0;
        res_data.found_time    <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  // Occupancy never exceeds the table depth
  assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("occupancy above table depth");

  // Ring pointers meet when the table is empty or full
  assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FULL_CNT) |-> (tail == head))
    else $error("head and tail disagree with occupancy");

  // Compaction never reads the slot it is writing
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && rd_en) |-> (wr_addr != rd_addr))
    else $error("memory read and write collide");

  // A finished compaction always removes an existing entry
  assert property (@(posedge clk) disable iff (rst) sh_done |-> (count != '0))
    else $error("compaction on an empty table");

  // A result is loaded only into a free output register
  assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> (!res_valid || res_ready))
    else $error("result overwritten before it was taken");
`endif

endmodule

// ----- hdl/match_and_remove_request_table_core.sv -----
// Top level of the pending request table: controller plus ring-buffer datapath.
// Add request: ST_ADD writes the entry, and ST_DONE registers the result once the output
// register is free; ST_IDLE then takes the next request. Find request: one memory read
// per stored entry until the oldest match; ST_SHIFT then moves younger entries into the gap.
// One request is in flight at a time; the single-port scan of the entry memory sets the rate.
// Synchronous reset empties the table at once (occupancy and pointers); no clearing pass.
module match_and_remove_request_table_core #(
  parameter int TABLE_DEPTH = 128,
  parameter int DROP_COUNT  = 30
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mrrt_pkg::req_t  req_data,
  output logic           res_valid,
  input  logic           res_ready,
  output mrrt_pkg::res_t  res_data
);
  import mrrt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  mrrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table storage and compare
  mrrt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DROP_COUNT  (DROP_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule
